// ----- design/mcs_pkg.sv -----
// ---------------------------------------------------------------------------
// Macro call splitter package
// Shared item types, codes and sizes for the macro call splitter.
// ---------------------------------------------------------------------------
package mcs_pkg;

    localparam int MAX_NAME    = 16;
    localparam int WIN_DEPTH   = MAX_NAME + 1;
    localparam int NEST_WIDTH  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int COUNT_W = $clog2(WIN_DEPTH + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CLOSE_PAREN = 8'h29;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [1:0] PART_PRE    = 2'd0;
    localparam logic [1:0] PART_PARAM  = 2'd1;
    localparam logic [1:0] PART_POST   = 2'd2;
    localparam logic [1:0] PART_STATUS = 2'd3;

    localparam logic [1:0] STATUS_SCANNING     = 2'd0;
    localparam logic [1:0] STATUS_FOUND        = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND    = 2'd2;
    localparam logic [1:0] STATUS_UNTERMINATED = 2'd3;

    localparam logic [1:0] CFG_NAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_NAME_LOW    = 2'd1;
    localparam logic [1:0] CFG_NAME_HIGH   = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] part;
        logic [1:0] status;
        logic       end_of_run;
    } out_item_t;

    // One queue entry: a snapshot of the window, the run of held bytes to
    // release oldest first, and an optional closing result.
    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] win;
        logic [COUNT_W-1:0]        top;
        logic [COUNT_W-1:0]        cnt;
        logic                      has_tail;
        logic [7:0]                tail_byte;
        logic [1:0]                tail_part;
        logic [1:0]                tail_status;
    } entry_t;

endpackage

// ----- design/mcs_front.sv -----
// ---------------------------------------------------------------------------
// Macro call splitter front end
// Accepts items, runs the name search and nesting count, and queues work.
// ---------------------------------------------------------------------------
module mcs_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  mcs_pkg::in_item_t                     in_item,
    input  logic [mcs_pkg::COUNT_W-1:0]           name_len,
    input  logic [mcs_pkg::MAX_NAME-1:0][7:0]     name_bytes,
    input  logic                                  queue_full,
    output logic                                  push,
    output mcs_pkg::entry_t                       push_entry
);

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_PARAM,
        MODE_POST
    } mode_t;

    mode_t                                 mode_reg, mode_next;
    logic [mcs_pkg::COUNT_W-1:0]           count_reg, count_next;
    logic [mcs_pkg::MAX_NAME-1:0][7:0]     hist_reg, hist_next;
    logic [mcs_pkg::NEST_WIDTH-1:0]        nest_reg, nest_next;

    logic                                  accept;
    logic [mcs_pkg::WIN_DEPTH-1:0][7:0]    snap;
    logic [mcs_pkg::COUNT_W-1:0]           c1;
    logic [mcs_pkg::COUNT_W-1:0]           plen;
    logic                                  match;
    logic [mcs_pkg::COUNT_W-1:0]           name_idx;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign snap     = {hist_reg, in_item.text_byte};
    assign c1       = count_reg + mcs_pkg::COUNT_W'(1);
    assign plen     = name_len + mcs_pkg::COUNT_W'(1);

    always_comb
    begin
        match    = (snap[0] == mcs_pkg::OPEN_PAREN);
        name_idx = '0;
        for (int j = 1; j < mcs_pkg::WIN_DEPTH; j++)
        begin
            name_idx = name_len - mcs_pkg::COUNT_W'(j);
            if (mcs_pkg::COUNT_W'(j) <= name_len)
            begin
                if (snap[j] != name_bytes[name_idx[$clog2(mcs_pkg::MAX_NAME)-1:0]])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        hist_next  = hist_reg;
        nest_next  = nest_reg;
        push       = 1'b0;
        push_entry.win         = snap;
        push_entry.top         = c1 - mcs_pkg::COUNT_W'(1);
        push_entry.cnt         = '0;
        push_entry.has_tail    = 1'b0;
        push_entry.tail_byte   = in_item.text_byte;
        push_entry.tail_part   = mcs_pkg::PART_PARAM;
        push_entry.tail_status = mcs_pkg::STATUS_SCANNING;

        if (accept)
        begin
            if (in_item.operation == mcs_pkg::OP_END)
            begin
                push                 = 1'b1;
                push_entry.has_tail  = 1'b1;
                push_entry.tail_byte = 8'd0;
                push_entry.tail_part = mcs_pkg::PART_STATUS;
                push_entry.top       = count_reg;
                case (mode_reg)
                    MODE_SEARCH:
                    begin
                        push_entry.cnt         = count_reg;
                        push_entry.tail_status = mcs_pkg::STATUS_NOT_FOUND;
                    end
                    MODE_PARAM:
                    begin
                        push_entry.tail_status = mcs_pkg::STATUS_UNTERMINATED;
                    end
                    default:
                    begin
                        push_entry.tail_status = mcs_pkg::STATUS_FOUND;
                    end
                endcase
                mode_next  = MODE_SEARCH;
                count_next = '0;
                nest_next  = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_SEARCH:
                    begin
                        hist_next = snap[mcs_pkg::MAX_NAME-1:0];
                        if (c1 < plen)
                        begin
                            count_next = c1;
                        end
                        else if (match)
                        begin
                            push_entry.cnt = c1 - plen;
                            push           = (c1 != plen);
                            mode_next      = MODE_PARAM;
                            count_next     = '0;
                            nest_next      = '0;
                        end
                        else
                        begin
                            push_entry.cnt = c1 - name_len;
                            push           = 1'b1;
                            count_next     = name_len;
                        end
                    end
                    MODE_PARAM:
                    begin
                        push_entry.has_tail = 1'b1;
                        push                = 1'b1;
                        if (in_item.text_byte == mcs_pkg::CLOSE_PAREN)
                        begin
                            if (nest_reg == '0)
                            begin
                                push      = 1'b0;
                                mode_next = MODE_POST;
                            end
                            else
                            begin
                                nest_next = nest_reg - mcs_pkg::NEST_WIDTH'(1);
                            end
                        end
                        else if (in_item.text_byte == mcs_pkg::OPEN_PAREN && nest_reg != '1)
                        begin
                            nest_next = nest_reg + mcs_pkg::NEST_WIDTH'(1);
                        end
                    end
                    default:
                    begin
                        push                 = 1'b1;
                        push_entry.has_tail  = 1'b1;
                        push_entry.tail_part = mcs_pkg::PART_POST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SEARCH;
            count_reg <= '0;
            nest_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            nest_reg  <= nest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

endmodule

// ----- design/mcs_queue.sv -----
// ---------------------------------------------------------------------------
// Macro call splitter work queue
// Short first-in first-out queue of work entries between front and back.
// ---------------------------------------------------------------------------
module mcs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mcs_pkg::entry_t      push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output mcs_pkg::entry_t      head
);

    mcs_pkg::entry_t               q_mem [mcs_pkg::QUEUE_DEPTH];
    logic [mcs_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mcs_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mcs_pkg::QCNT_W-1:0]    count_reg;

    assign full       = (count_reg == mcs_pkg::QCNT_W'(mcs_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mcs_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mcs_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + mcs_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - mcs_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ----- design/mcs_back.sv -----
// ---------------------------------------------------------------------------
// Macro call splitter back end
// Plays out queued work as result items through a registered output.
// ---------------------------------------------------------------------------
module mcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  mcs_pkg::entry_t      head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mcs_pkg::out_item_t   out_item
);

    logic [mcs_pkg::COUNT_W-1:0]   done_reg, done_next;
    logic                          out_valid_reg, out_valid_next;
    mcs_pkg::out_item_t            out_item_reg, out_item_next;

    logic                          advance;
    logic                          pre_phase;
    logic                          last;
    logic [mcs_pkg::COUNT_W-1:0]   idx;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign pre_phase = (done_reg != head.cnt);
    assign idx       = head.top - done_reg;
    assign last      = pre_phase ?
                       ((done_reg == head.cnt - mcs_pkg::COUNT_W'(1)) && !head.has_tail) : 1'b1;
    assign pop       = advance && last;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (pre_phase)
            begin
                out_item_next.out_byte = head.win[idx];
                out_item_next.part     = mcs_pkg::PART_PRE;
                out_item_next.status   = mcs_pkg::STATUS_SCANNING;
            end
            else
            begin
                out_item_next.out_byte = head.tail_byte;
                out_item_next.part     = head.tail_part;
                out_item_next.status   = head.tail_status;
            end
            out_item_next.end_of_run = last;
            done_next = last ? '0 : done_reg + mcs_pkg::COUNT_W'(1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

// ----- design/macro_call_splitter_top.sv -----
// ---------------------------------------------------------------------------
// Macro call splitter
// Splits a text stream around the first call of a configured macro name.
// ---------------------------------------------------------------------------
// The input channel takes one item per cycle: a text byte or an end of
// string. The output channel gives result items tagged pre, parameter,
// post or status, with end_of_run on the last result of each input item.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// The front end decides each item and places its work in a four-entry
// queue. The back end releases one result per cycle while the output
// is not stalled, so an item with one result sustains one item per
// cycle; an item that releases k held bytes holds the back end until
// all are out. With the queue empty, an item's first result passes the
// queue and then the output register. When the receiver stalls, the
// output register holds its item and the queue fills; the input stalls
// only while the queue is full. Reset empties the queue and returns to
// searching with a name length of one and a zero name. Configuration is to
// be written by the user only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module macro_call_splitter_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mcs_pkg::in_item_t     in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output mcs_pkg::out_item_t    out_item,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    logic [4:0]                            name_length_reg;
    logic [63:0]                           name_low_reg;
    logic [63:0]                           name_high_reg;
    logic [mcs_pkg::COUNT_W-1:0]           name_len;
    logic [mcs_pkg::MAX_NAME-1:0][7:0]     name_bytes;

    logic                                  push;
    mcs_pkg::entry_t                       push_entry;
    logic                                  queue_full;
    logic                                  pop;
    logic                                  head_valid;
    mcs_pkg::entry_t                       head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= 5'd1;
            name_low_reg    <= '0;
            name_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mcs_pkg::CFG_NAME_LENGTH: name_length_reg <= cfg_data[4:0];
                mcs_pkg::CFG_NAME_LOW:    name_low_reg    <= cfg_data;
                mcs_pkg::CFG_NAME_HIGH:   name_high_reg   <= cfg_data;
                default:                  name_low_reg    <= name_low_reg;
            endcase
        end
    end

    always_comb
    begin
        if (name_length_reg == 5'd0)
        begin
            name_len = mcs_pkg::COUNT_W'(1);
        end
        else if (mcs_pkg::COUNT_W'(name_length_reg) > mcs_pkg::COUNT_W'(mcs_pkg::MAX_NAME))
        begin
            name_len = mcs_pkg::COUNT_W'(mcs_pkg::MAX_NAME);
        end
        else
        begin
            name_len = mcs_pkg::COUNT_W'(name_length_reg);
        end
    end

    assign name_bytes = {name_high_reg, name_low_reg};

    mcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .name_len   (name_len),
        .name_bytes (name_bytes),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Macro call splitter testbench
// Sends text strings that hold calls of a configured macro name, along with
// near misses, unterminated calls and noise. A predictor inside this module
// follows the search window, the nesting depth and the end-of-string flush,
// and every output item is checked against it. Both channels idle at random,
// the receiver holds off once for a long stretch, and a final string nests
// brackets several levels deep.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 8;
    localparam int DEEP_OPENS  = 4;

    typedef enum logic [1:0] {TRACK_SEARCH, TRACK_PARAM, TRACK_POST} track_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    mcs_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    mcs_pkg::out_item_t out_item;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    mcs_pkg::in_item_t  text_queue[$];
    mcs_pkg::out_item_t expected_pieces[$];
    mcs_pkg::out_item_t item_pieces[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic send_paused = 1'b0;
    logic hold_request = 1'b0;
    int hold_left;
    int cycle_count = 0;
    int error_count = 0;
    int items_queued = 0;

    logic [4:0]  name_len_reg;
    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;
    track_t      track_mode;
    logic [7:0]  window_bytes [mcs_pkg::WIN_DEPTH];
    int          window_fill;
    logic [mcs_pkg::NEST_WIDTH-1:0] nest_depth;

    int         gen_len;
    logic [7:0] gen_name [mcs_pkg::MAX_NAME];

    macro_call_splitter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int name_span();
        if (name_len_reg == 5'd0)
            return 1;
        if (int'(name_len_reg) > mcs_pkg::MAX_NAME)
            return mcs_pkg::MAX_NAME;
        return int'(name_len_reg);
    endfunction

    function automatic logic [7:0] pattern_at(input int i, input int len);
        if (i >= len)
            return mcs_pkg::OPEN_PAREN;
        if (i < 8)
            return name_low_reg[8*i +: 8];
        return name_high_reg[8*(i-8) +: 8];
    endfunction

    task automatic add_piece(input logic [7:0] b, input logic [1:0] part,
                             input logic [1:0] status);
        mcs_pkg::out_item_t p;
        p.out_byte   = b;
        p.part       = part;
        p.status     = status;
        p.end_of_run = 1'b0;
        item_pieces.push_back(p);
    endtask

    task automatic release_oldest(input int k);
        int n;
        n = (k > window_fill) ? window_fill : k;
        for (int i = 0; i < n; i++)
            add_piece(window_bytes[i], mcs_pkg::PART_PRE, mcs_pkg::STATUS_SCANNING);
        for (int i = 0; i < window_fill - n; i++)
            window_bytes[i] = window_bytes[i + n];
        window_fill = window_fill - n;
    endtask

    task automatic split_item(input mcs_pkg::in_item_t it);
        int len;
        int first;
        logic matched;
        mcs_pkg::out_item_t p;
        item_pieces.delete();
        if (it.operation == mcs_pkg::OP_END)
        begin
            if (track_mode == TRACK_SEARCH)
            begin
                release_oldest(window_fill);
                add_piece(8'h00, mcs_pkg::PART_STATUS, mcs_pkg::STATUS_NOT_FOUND);
            end
            else if (track_mode == TRACK_PARAM)
                add_piece(8'h00, mcs_pkg::PART_STATUS, mcs_pkg::STATUS_UNTERMINATED);
            else
                add_piece(8'h00, mcs_pkg::PART_STATUS, mcs_pkg::STATUS_FOUND);
            track_mode  = TRACK_SEARCH;
            window_fill = 0;
            nest_depth  = '0;
        end
        else if (track_mode == TRACK_SEARCH)
        begin
            len = name_span();
            if (window_fill >= mcs_pkg::WIN_DEPTH)
                release_oldest(1);
            window_bytes[window_fill] = it.text_byte;
            window_fill = window_fill + 1;
            if (window_fill >= len + 1)
            begin
                first = window_fill - (len + 1);
                matched = 1'b1;
                for (int i = 0; i <= len; i++)
                    if (window_bytes[first + i] != pattern_at(i, len))
                        matched = 1'b0;
                if (matched)
                begin
                    release_oldest(first);
                    window_fill = 0;
                    nest_depth  = '0;
                    track_mode  = TRACK_PARAM;
                end
                else
                    release_oldest(window_fill - len);
            end
        end
        else if (track_mode == TRACK_PARAM)
        begin
            if (it.text_byte == mcs_pkg::CLOSE_PAREN && nest_depth == '0)
                track_mode = TRACK_POST;
            else
            begin
                if (it.text_byte == mcs_pkg::CLOSE_PAREN)
                    nest_depth = nest_depth - mcs_pkg::NEST_WIDTH'(1);
                else if (it.text_byte == mcs_pkg::OPEN_PAREN && nest_depth != '1)
                    nest_depth = nest_depth + mcs_pkg::NEST_WIDTH'(1);
                add_piece(it.text_byte, mcs_pkg::PART_PARAM, mcs_pkg::STATUS_SCANNING);
            end
        end
        else
            add_piece(it.text_byte, mcs_pkg::PART_POST, mcs_pkg::STATUS_SCANNING);
        for (int i = 0; i < item_pieces.size(); i++)
        begin
            p = item_pieces[i];
            p.end_of_run = (i == item_pieces.size() - 1);
            expected_pieces.push_back(p);
        end
    endtask

    task automatic note_error(input string msg);
        error_count = error_count + 1;
        if (error_count <= 10)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_piece(input mcs_pkg::out_item_t got);
        mcs_pkg::out_item_t want;
        if (expected_pieces.size() == 0)
        begin
            note_error($sformatf("unexpected item byte=%h part=%0d status=%0d end=%0b",
                                 got.out_byte, got.part, got.status, got.end_of_run));
            return;
        end
        want = expected_pieces.pop_front();
        if (got.out_byte !== want.out_byte || got.part !== want.part ||
            got.status !== want.status || got.end_of_run !== want.end_of_run)
            note_error($sformatf({"expected byte=%h part=%0d status=%0d end=%0b, ",
                                  "got byte=%h part=%0d status=%0d end=%0b"},
                                 want.out_byte, want.part, want.status, want.end_of_run,
                                 got.out_byte, got.part, got.status, got.end_of_run));
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (text_queue.size() != 0 && !send_paused &&
                $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_item  <= text_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_request)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_len_reg  = 5'd1;
            name_low_reg  = '0;
            name_high_reg = '0;
            track_mode    = TRACK_SEARCH;
            window_fill   = 0;
            nest_depth    = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == mcs_pkg::CFG_NAME_LENGTH)
                    name_len_reg = cfg_data[4:0];
                else if (cfg_index == mcs_pkg::CFG_NAME_LOW)
                    name_low_reg = cfg_data;
                else if (cfg_index == mcs_pkg::CFG_NAME_HIGH)
                    name_high_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                split_item(in_item);
            if (out_valid && !out_stall)
                check_piece(out_item);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        mcs_pkg::in_item_t it;
        it.operation = mcs_pkg::OP_TEXT;
        it.text_byte = b;
        text_queue.push_back(it);
        items_queued = items_queued + 1;
    endtask

    task automatic queue_end();
        mcs_pkg::in_item_t it;
        it.operation = mcs_pkg::OP_END;
        it.text_byte = 8'($urandom_range(0, 255));
        text_queue.push_back(it);
        items_queued = items_queued + 1;
    endtask

    function automatic logic [63:0] name_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == mcs_pkg::OPEN_PAREN || b == mcs_pkg::CLOSE_PAREN)
            b = b ^ 8'h40;
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return mcs_pkg::OPEN_PAREN;
            1: return mcs_pkg::CLOSE_PAREN;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_name(input logic [4:0] len, input logic [63:0] lo,
                            input logic [63:0] hi);
        write_reg(mcs_pkg::CFG_NAME_LENGTH, {59'd0, len});
        write_reg(mcs_pkg::CFG_NAME_LOW, lo);
        write_reg(mcs_pkg::CFG_NAME_HIGH, hi);
        gen_len = (len == 5'd0) ? 1 :
                  (int'(len) > mcs_pkg::MAX_NAME) ? mcs_pkg::MAX_NAME : int'(len);
        for (int i = 0; i < mcs_pkg::MAX_NAME; i++)
            gen_name[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endtask

    task automatic wait_results();
        do
            @(negedge clk);
        while (in_valid || expected_pieces.size() != 0);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_queue.size() != 0);
        wait_results();
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic queue_call_string();
        int kind;
        int n;
        int depth;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            n = $urandom_range(0, 12);
            repeat (n) queue_byte(noise_byte());
        end
        else
        begin
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    depth = $urandom_range(1, gen_len);
                    for (int i = 0; i < depth; i++)
                        queue_byte(gen_name[i]);
                end
                queue_byte(noise_byte());
            end
            for (int i = 0; i < gen_len; i++)
                queue_byte(gen_name[i]);
            if (kind != 8)
                queue_byte(mcs_pkg::OPEN_PAREN);
            depth = 0;
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        queue_byte(mcs_pkg::OPEN_PAREN);
                        depth = depth + 1;
                    end
                    1:
                    begin
                        if (depth > 0)
                        begin
                            queue_byte(mcs_pkg::CLOSE_PAREN);
                            depth = depth - 1;
                        end
                        else
                            queue_byte(plain_byte());
                    end
                    default: queue_byte(plain_byte());
                endcase
            end
            if (kind != 7)
            begin
                repeat (depth) queue_byte(mcs_pkg::CLOSE_PAREN);
                queue_byte(mcs_pkg::CLOSE_PAREN);
                n = $urandom_range(0, 4);
                repeat (n) queue_byte(noise_byte());
            end
        end
        queue_end();
    endtask

    initial
    begin
        logic [4:0]  slot_len [6];
        logic [63:0] lo;
        logic [63:0] hi;
        int start;

        slot_len = '{5'd0, 5'd3, 5'd16, 5'd31, 5'd2, 5'd1};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 7;
        recv_idle_pct = 55;

        // Reset name is a single zero byte, so a zero byte followed by '(' is a call.
        queue_byte("a");
        queue_byte(8'h00);
        queue_byte(mcs_pkg::OPEN_PAREN);
        queue_byte("x");
        queue_byte(mcs_pkg::CLOSE_PAREN);
        queue_byte("y");
        queue_end();
        queue_byte("b");
        queue_end();
        queue_end();
        wait_idle();

        set_name(5'd2, name_word("fo"), '0);
        queue_byte("f");
        queue_byte("f");
        queue_byte("o");
        queue_byte(mcs_pkg::OPEN_PAREN);
        queue_byte(mcs_pkg::OPEN_PAREN);
        queue_byte(mcs_pkg::CLOSE_PAREN);
        queue_byte(mcs_pkg::CLOSE_PAREN);
        queue_byte("d");
        queue_end();
        queue_byte("f");
        queue_byte("o");
        queue_byte(mcs_pkg::OPEN_PAREN);
        queue_byte("a");
        queue_end();
        wait_idle();

        // The name shrinks while a string is in progress.
        set_name(5'd4, name_word("abcd"), '0);
        queue_byte("x");
        queue_byte("a");
        wait_idle();
        write_reg(mcs_pkg::CFG_NAME_LENGTH, 64'd1);
        queue_byte(mcs_pkg::OPEN_PAREN);
        queue_byte("z");
        queue_byte(mcs_pkg::CLOSE_PAREN);
        queue_end();
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 7 : 0;
            for (int slot = 2 * phase; slot < 2 * phase + 2; slot++)
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                if (slot == 2)
                begin
                    lo = '1;
                    hi = '1;
                end
                else if (slot == 5)
                begin
                    lo = '0;
                    hi = '0;
                end
                wait_idle();
                set_name(slot_len[slot], lo, hi);
                start = items_queued;
                queue_call_string();
                if (slot == 2 * phase)
                begin
                    do
                        @(negedge clk);
                    while (text_queue.size() != 0);
                    send_paused = 1'b1;
                    wait_results();
                    send_paused = 1'b0;
                end
                while (items_queued - start < PHASE_ITEMS)
                    queue_call_string();
                if (slot == 0)
                begin
                    // Items stay on offer while the receiver holds off.
                    queue_call_string();
                    @(posedge clk);
                    hold_request <= 1'b1;
                    @(posedge clk);
                    hold_request <= 1'b0;
                    @(negedge clk);
                end
            end
        end
        wait_idle();

        // Brackets nested several levels deep inside a call.
        set_name(5'd1, name_word("m"), '0);
        queue_byte("m");
        queue_byte(mcs_pkg::OPEN_PAREN);
        repeat (DEEP_OPENS) queue_byte(mcs_pkg::OPEN_PAREN);
        repeat (3) queue_byte(mcs_pkg::CLOSE_PAREN);
        queue_end();
        wait_idle();
        repeat (20) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
